>>> hdl/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/spmv_pkg.sv
package spmv_pkg;

	localparam logic [1:0] CMD_ENTRY   = 2'd0;
	localparam logic [1:0] CMD_ROW     = 2'd1;
	localparam logic [1:0] CMD_VECTOR  = 2'd2;
	localparam logic [1:0] CMD_COMPUTE = 2'd3;

	localparam int ACC_W = 40;
	localparam int SUM_W = 32;

	typedef struct packed {
		logic        [1:0]  cmd;
		logic        [11:0] index;
		logic signed [15:0] value;
		logic        [9:0]  column;
		logic        [12:0] start_offset;
	} in_word_t;

	typedef struct packed {
		logic        [9:0]  row_number;
		logic signed [31:0] row_sum;
		logic               saturated;
		logic               bad_row;
	} out_word_t;

	typedef struct packed {
		logic clr;
		logic vld;
	} mac_ctl_t;

endpackage

>>> hdl/spmv_ram.sv
module spmv_ram #(
	parameter int W  = 16,
	parameter int D  = 1024,
	parameter int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/spmv_mac.sv
module spmv_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spmv_pkg::mac_ctl_t                ctl,
	input  logic signed [15:0]                a,
	input  logic signed [15:0]                b,
	output logic signed [spmv_pkg::ACC_W-1:0] acc,
	output logic                              sat,
	output logic                              busy
);

	import spmv_pkg::*;

	logic signed [31:0]    prod_s3;
	logic                  vld_s3;
	logic signed [ACC_W:0] sum;
	logic                  ovf;

	assign sum  = (ACC_W+1)'(acc) + (ACC_W+1)'(prod_s3);
	assign ovf  = sum[ACC_W] != sum[ACC_W-1];
	assign busy = vld_s3;

	always_ff @(posedge clk) begin
		prod_s3 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			acc    <= '0;
			sat    <= 1'b0;
		end else begin
			vld_s3 <= ctl.vld & ~ctl.clr;
			if (ctl.clr) begin
				acc <= '0;
				sat <= 1'b0;
			end else if (vld_s3) begin
				if (ovf) begin
					acc <= sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
					sat <= 1'b1;
				end else begin
					acc <= sum[ACC_W-1:0];
				end
			end
		end
	end

endmodule

>>> hdl/csr_sparse_matrix_vector_multiply_top.sv
// Loads (entry, row start, vector element) are taken only while not busy and may follow back to back.
// A compute word gives done after two row start reads, then one entry a cycle through
// entry read, vector read, multiply and accumulate, then the drain; an empty row skips
// the entries. busy drops with done, so the next word may be taken in the done cycle.
// A rejected row reports without any row start read, a reversed range after both reads.
// done is a one-cycle strobe, never held off. Reset clears control, rows_q is 1.
module csr_sparse_matrix_vector_multiply_top #(
	parameter int MAX_ENTRIES = 4096,
	parameter int MAX_ROWS    = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  spmv_pkg::in_word_t  req,
	output logic                done,
	output spmv_pkg::out_word_t result,
	input  logic                cfg_we,
	input  logic [10:0]         cfg_wdata
);

	import spmv_pkg::*;

	localparam int EW  = $clog2(MAX_ENTRIES);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int RSW = $clog2(MAX_ROWS + 1);
	localparam int KW  = (EW + 1 > 13) ? EW + 1 : 13;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FIRST = 4'b0010,
		S_LAST  = 4'b0100,
		S_RUN   = 4'b1000
	} state_t;

	state_t       state_q;
	logic [10:0]  rows_q;
	logic [11:0]  idx_q;
	logic [12:0]  first_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] end_q;
	logic         v_s1;
	logic         v_s2;
	logic signed [15:0] val_s2;
	logic         cok_s2;
	logic         done_q;
	out_word_t    res_q;

	logic         accept;
	logic         row_bad;
	logic         issue;
	logic         drained;
	logic [KW-1:0] last_c;

	logic [RSW-1:0] rs_raddr;
	logic [12:0]    rs_rdata;
	logic [25:0]    ent_rdata;
	logic [15:0]    vec_rdata;

	mac_ctl_t                mac_ctl;
	logic signed [ACC_W-1:0] acc;
	logic                    acc_sat;
	logic                    mac_busy;
	logic                    clamp_ovf;
	logic signed [SUM_W-1:0] sum32;

	assign busy    = state_q != S_IDLE;
	assign accept  = start & ~busy;
	assign row_bad = (32'(req.index) >= 32'(rows_q)) || (32'(req.index) >= MAX_ROWS);
	assign issue   = (state_q == S_RUN) && (k_q < end_q);
	assign drained = ~issue & ~v_s1 & ~v_s2 & ~mac_busy;
	assign last_c  = (32'(rs_rdata) > MAX_ENTRIES) ? KW'(MAX_ENTRIES) : KW'(rs_rdata);
	assign rs_raddr = (state_q == S_IDLE) ? RSW'(req.index) : RSW'(idx_q + 12'd1);

	assign clamp_ovf = !((&acc[ACC_W-1:SUM_W-1]) || !(|acc[ACC_W-1:SUM_W-1]));
	assign sum32     = clamp_ovf ? (acc[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff)
	                             : acc[SUM_W-1:0];

	assign mac_ctl.clr = (state_q == S_LAST);
	assign mac_ctl.vld = v_s2;

	assign done   = done_q;
	assign result = res_q;

	spmv_ram #(.W(26), .D(MAX_ENTRIES), .AW(EW)) u_entries (
		.clk   (clk),
		.we    (accept && req.cmd == CMD_ENTRY && 32'(req.index) < MAX_ENTRIES),
		.waddr (EW'(req.index)),
		.wdata ({req.value, req.column}),
		.raddr (k_q[EW-1:0]),
		.rdata (ent_rdata)
	);

	spmv_ram #(.W(13), .D(MAX_ROWS + 1), .AW(RSW)) u_row_starts (
		.clk   (clk),
		.we    (accept && req.cmd == CMD_ROW && 32'(req.index) <= MAX_ROWS),
		.waddr (RSW'(req.index)),
		.wdata (req.start_offset),
		.raddr (rs_raddr),
		.rdata (rs_rdata)
	);

	spmv_ram #(.W(16), .D(MAX_ROWS), .AW(RW)) u_vector (
		.clk   (clk),
		.we    (accept && req.cmd == CMD_VECTOR && 32'(req.index) < MAX_ROWS),
		.waddr (RW'(req.index)),
		.wdata (req.value),
		.raddr (RW'(ent_rdata[9:0])),
		.rdata (vec_rdata)
	);

	spmv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (val_s2),
		.b      (cok_s2 ? $signed(vec_rdata) : 16'sd0),
		.acc    (acc),
		.sat    (acc_sat),
		.busy   (mac_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rows_q  <= 11'd1;
			done_q  <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= issue;
			v_s2   <= v_s1;
			if (cfg_we) begin
				rows_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && req.cmd == CMD_COMPUTE) begin
						if (row_bad) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_FIRST;
						end
					end
				end
				S_FIRST: begin
					state_q <= S_LAST;
				end
				S_LAST: begin
					if (first_q > rs_rdata) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (drained) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		val_s2 <= ent_rdata[25:10];
		cok_s2 <= 32'(ent_rdata[9:0]) < MAX_ROWS;
		if (issue) begin
			k_q <= k_q + KW'(1);
		end
		case (state_q)
			S_IDLE: begin
				idx_q <= req.index;
				res_q <= '{row_number: req.index[9:0], row_sum: '0,
				           saturated: 1'b0, bad_row: 1'b1};
			end
			S_FIRST: begin
				first_q <= rs_rdata;
			end
			S_LAST: begin
				k_q   <= KW'(first_q);
				end_q <= last_c;
			end
			S_RUN: begin
				res_q <= '{row_number: idx_q[9:0], row_sum: sum32,
				           saturated: acc_sat | clamp_ovf, bad_row: 1'b0};
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	`include "assert_macros.svh"

	`ASSERT_IMPL(a_bad_zero, clk, arst_n, done && result.bad_row, result.row_sum == 0 && !result.saturated, "rejected row with nonzero sum")
	`ASSERT_CLK(a_busy_cause, clk, arst_n, $rose(busy) |-> $past(start && req.cmd == CMD_COMPUTE), "busy without a compute word")
	`ASSERT_IMPL(a_done_idle, clk, arst_n, done && !result.bad_row, $past(state_q == S_RUN) && !busy, "good result outside row run")

endmodule
